// ===== hw/rtl/sff_pkg.sv =====
// Shared types, opcodes and default parameters of the sector flood fill unit.
package sff_pkg;

    localparam int SFF_MAP_WIDTH   = 64;
    localparam int SFF_MAP_HEIGHT  = 64;
    localparam int SFF_SECTOR_SIZE = 16;
    localparam int SFF_TILE_BITS   = 16;

    // Width of a map coordinate plus an in-sector offset.
    localparam int SFF_CW = 8;

    typedef enum logic [1:0] {
        SFF_OP_WRITE  = 2'd0,
        SFF_OP_READ   = 2'd1,
        SFF_OP_FILL   = 2'd2,
        SFF_OP_UNUSED = 2'd3
    } sff_op_t;

    typedef struct packed {
        logic shift;
        logic prop;
    } sff_ctrl_t;

endpackage

// ===== hw/rtl/sff_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module sff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/sff_cell.sv =====
// One sector tile cell: holds its match and visited marks and spreads the fill.
module sff_cell
    import sff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sff_ctrl_t ctrl,
    input  logic      match_in,
    input  logic      visit_in,
    input  logic [3:0] nbr_visit,
    output logic      match_q,
    output logic      visit_q
);

    logic match_reg, match_next;
    logic visit_reg, visit_next;

    always_comb
    begin
        match_next = match_reg;
        visit_next = visit_reg;
        if (ctrl.shift)
        begin
            match_next = match_in;
            visit_next = visit_in;
        end
        else if (ctrl.prop)
        begin
            visit_next = visit_reg | (match_reg & (|nbr_visit));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            visit_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            visit_reg <= visit_next;
        end
    end

    assign match_q = match_reg;
    assign visit_q = visit_reg;

endmodule

// ===== hw/rtl/sff_cell_row.sv =====
// Row of sector cells, chained for serial load and unload and meshed for the fill.
module sff_cell_row
    import sff_pkg::*;
#(
    parameter int SECTOR_SIZE = SFF_SECTOR_SIZE
) (
    input  logic      clk,
    input  logic      rst_n,
    input  sff_ctrl_t ctrl,
    input  logic      load_match,
    input  logic      load_visit,
    output logic      out_visit
);

    localparam int N = SECTOR_SIZE * SECTOR_SIZE;

    logic [N-1:0] match_w;
    logic [N-1:0] visit_w;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        localparam int LX = k % SECTOR_SIZE;
        localparam int LY = k / SECTOR_SIZE;
        logic [3:0] nbr;
        logic       m_in;
        logic       v_in;

        if (LY < SECTOR_SIZE - 1)
        begin : g_dn
            assign nbr[0] = visit_w[k+SECTOR_SIZE];
        end
        else
        begin : g_ndn
            assign nbr[0] = 1'b0;
        end
        if (LY > 0)
        begin : g_up
            assign nbr[1] = visit_w[k-SECTOR_SIZE];
        end
        else
        begin : g_nup
            assign nbr[1] = 1'b0;
        end
        if (LX < SECTOR_SIZE - 1)
        begin : g_rt
            assign nbr[2] = visit_w[k+1];
        end
        else
        begin : g_nrt
            assign nbr[2] = 1'b0;
        end
        if (LX > 0)
        begin : g_lt
            assign nbr[3] = visit_w[k-1];
        end
        else
        begin : g_nlt
            assign nbr[3] = 1'b0;
        end

        if (k == N - 1)
        begin : g_top
            assign m_in = load_match;
            assign v_in = load_visit;
        end
        else
        begin : g_mid
            assign m_in = match_w[k+1];
            assign v_in = visit_w[k+1];
        end

        sff_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .match_in  (m_in),
            .visit_in  (v_in),
            .nbr_visit (nbr),
            .match_q   (match_w[k]),
            .visit_q   (visit_w[k])
        );
    end

    assign out_visit = visit_w[0];

endmodule

// ===== hw/rtl/sector_flood_fill_unit.sv =====
// Top level of the sector flood fill unit: tile map, sequencer and cell row.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: opcode; tdata: tile_x, tile_y, tile_value
// m_*      out  m_tvalid/m_tready  tdata: read_data, changed_count
//
// A write goes straight to the output stage, a read first waits for the registered map read,
// and a fill reads its seed and ends there if the seed already holds the new code. Other fills
// load the N = SECTOR_SIZE squared cells, spread the fill, write it back and then output.
// Reset clears all control state; the tile map holds no reset value.
// A new item is taken only once the previous one has reached the output register,
// which holds it while m_tready is low.
module sector_flood_fill_unit
    import sff_pkg::*;
#(
    parameter int MAP_WIDTH   = SFF_MAP_WIDTH,
    parameter int MAP_HEIGHT  = SFF_MAP_HEIGHT,
    parameter int SECTOR_SIZE = SFF_SECTOR_SIZE,
    parameter int TILE_BITS   = SFF_TILE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // tile_x[5:0], tile_y[11:6], tile_value[27:12]
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // read_data[15:0], changed_count[24:16]
);

    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int N     = SECTOR_SIZE * SECTOR_SIZE;
    localparam int NW    = $clog2(N + 1);
    localparam int LW    = (SECTOR_SIZE > 1) ? $clog2(SECTOR_SIZE) : 1;
    localparam int PW    = SFF_CW + $clog2(MAP_WIDTH) + 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RDWAIT = 7'b0000010,
        ST_SEED   = 7'b0000100,
        ST_LOAD   = 7'b0001000,
        ST_PROP   = 7'b0010000,
        ST_UNLOAD = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]           in_x, in_y;
    logic [TILE_BITS-1:0] in_code;
    sff_op_t              in_op;
    logic                 accept, in_inside;

    logic [SFF_CW-1:0]    bx_reg, bx_next, by_reg, by_next;
    logic [LW-1:0]        seed_lx_reg, seed_lx_next, seed_ly_reg, seed_ly_next;
    logic [LW-1:0]        lx_reg, lx_next, ly_reg, ly_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        fill_reg, fill_next, fill_inc;
    logic [TILE_BITS-1:0] code_reg, code_next, old_reg, old_next;
    logic                 p_valid_reg, p_valid_next;
    logic                 p_inmap_reg, p_inmap_next;
    logic                 p_seed_reg, p_seed_next;
    logic [15:0]          res_rd_reg, res_rd_next, out_rd_reg, out_rd_next;
    logic [8:0]           res_cnt_reg, res_cnt_next, out_cnt_reg, out_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic [SFF_CW-1:0]    gx, gy;
    logic                 inmap_cur;
    logic [AW-1:0]        grid_addr, seed_addr;
    logic [LW-1:0]        lx_adv, ly_adv;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [TILE_BITS-1:0] ram_wdata, ram_rdata;

    sff_ctrl_t            cell_ctrl;
    logic                 out_visit;

    assign in_x      = s_tdata[5:0];
    assign in_y      = s_tdata[11:6];
    assign in_code   = TILE_BITS'(s_tdata[27:12]);
    assign in_op     = sff_op_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_inside = (32'(in_x) < MAP_WIDTH) && (32'(in_y) < MAP_HEIGHT);

    assign gx        = bx_reg + SFF_CW'(lx_reg);
    assign gy        = by_reg + SFF_CW'(ly_reg);
    assign inmap_cur = (32'(gx) < MAP_WIDTH) && (32'(gy) < MAP_HEIGHT);
    assign grid_addr = AW'(PW'(gy) * PW'(MAP_WIDTH) + PW'(gx));
    assign seed_addr = AW'(PW'(in_y) * PW'(MAP_WIDTH) + PW'(in_x));
    assign lx_adv    = (lx_reg == LW'(SECTOR_SIZE - 1)) ? '0 : lx_reg + 1'b1;
    assign ly_adv    = (lx_reg == LW'(SECTOR_SIZE - 1)) ? ly_reg + 1'b1 : ly_reg;
    assign fill_inc  = fill_reg + NW'(out_visit);

    assign ram_raddr = (state_reg == ST_IDLE) ? seed_addr : grid_addr;
    assign ram_waddr = (state_reg == ST_IDLE) ? seed_addr : grid_addr;
    assign ram_wdata = (state_reg == ST_IDLE) ? in_code : code_reg;
    assign ram_we    = (accept && in_inside && in_op == SFF_OP_WRITE)
                    || (state_reg == ST_UNLOAD && out_visit);

    assign cell_ctrl.shift = (state_reg == ST_LOAD && p_valid_reg) || (state_reg == ST_UNLOAD);
    assign cell_ctrl.prop  = (state_reg == ST_PROP);

    always_comb
    begin
        state_next     = state_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        seed_lx_next   = seed_lx_reg;
        seed_ly_next   = seed_ly_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        code_next      = code_reg;
        old_next       = old_reg;
        p_valid_next   = 1'b0;
        p_inmap_next   = 1'b0;
        p_seed_next    = 1'b0;
        res_rd_next    = res_rd_reg;
        res_cnt_next   = res_cnt_reg;
        out_rd_next    = out_rd_reg;
        out_cnt_next   = out_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    code_next    = in_code;
                    bx_next      = SFF_CW'((32'(in_x) / SECTOR_SIZE) * SECTOR_SIZE);
                    by_next      = SFF_CW'((32'(in_y) / SECTOR_SIZE) * SECTOR_SIZE);
                    seed_lx_next = LW'(32'(in_x) % SECTOR_SIZE);
                    seed_ly_next = LW'(32'(in_y) % SECTOR_SIZE);
                    res_rd_next  = '0;
                    res_cnt_next = '0;
                    if (in_inside && in_op == SFF_OP_READ)
                    begin
                        state_next = ST_RDWAIT;
                    end
                    else if (in_inside && in_op == SFF_OP_FILL)
                    begin
                        state_next = ST_SEED;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RDWAIT:
            begin
                res_rd_next = 16'(ram_rdata);
                state_next  = ST_FINISH;
            end
            ST_SEED:
            begin
                old_next = ram_rdata;
                lx_next  = '0;
                ly_next  = '0;
                cnt_next = '0;
                if (ram_rdata == code_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg < NW'(N))
                begin
                    p_valid_next = 1'b1;
                    p_inmap_next = inmap_cur;
                    p_seed_next  = (lx_reg == seed_lx_reg) && (ly_reg == seed_ly_reg);
                    lx_next      = lx_adv;
                    ly_next      = ly_adv;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_PROP;
                end
            end
            ST_PROP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NW'(N - 1))
                begin
                    cnt_next   = '0;
                    lx_next    = '0;
                    ly_next    = '0;
                    fill_next  = '0;
                    state_next = ST_UNLOAD;
                end
            end
            ST_UNLOAD:
            begin
                fill_next = fill_inc;
                lx_next   = lx_adv;
                ly_next   = ly_adv;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == NW'(N - 1))
                begin
                    res_cnt_next = (32'(fill_inc) > 32'd511) ? 9'd511 : 9'(fill_inc);
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = res_rd_reg;
                    out_cnt_next   = res_cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            lx_reg        <= '0;
            ly_reg        <= '0;
            fill_reg      <= '0;
            p_valid_reg   <= 1'b0;
            p_inmap_reg   <= 1'b0;
            p_seed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lx_reg        <= lx_next;
            ly_reg        <= ly_next;
            fill_reg      <= fill_next;
            p_valid_reg   <= p_valid_next;
            p_inmap_reg   <= p_inmap_next;
            p_seed_reg    <= p_seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        seed_lx_reg <= seed_lx_next;
        seed_ly_reg <= seed_ly_next;
        code_reg    <= code_next;
        old_reg     <= old_next;
        res_rd_reg  <= res_rd_next;
        res_cnt_reg <= res_cnt_next;
        out_rd_reg  <= out_rd_next;
        out_cnt_reg <= out_cnt_next;
    end

    sff_ram #(
        .WIDTH (TILE_BITS),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sff_cell_row #(
        .SECTOR_SIZE (SECTOR_SIZE)
    ) u_cells (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cell_ctrl),
        .load_match (p_inmap_reg && (ram_rdata == old_reg)),
        .load_visit (p_seed_reg),
        .out_visit  (out_visit)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_cnt_reg, out_rd_reg};

    a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE || state_reg == ST_UNLOAD))
        else $error("map written outside write or write-back phase");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= N)
        else $error("sequencer counter out of range");

    a_prop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROP |=> (state_reg == ST_PROP || state_reg == ST_UNLOAD))
        else $error("fill spreading left early");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted item was not started");

endmodule

// ===== tb/sector_flood_fill_unit_check.sv =====
// Checker of the sector flood fill unit: predicts each result and compares it.
module sector_flood_fill_unit_check
    import sff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,  // tile_x[5:0], tile_y[11:6], tile_value[27:12]
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,  // read_data[15:0], changed_count[24:16]
    output int          error_count,
    output int          pending_count,
    output int          fill_results
);

    typedef struct packed {
        logic [15:0] read_data;
        logic [8:0]  changed_count;
    } tile_result_t;

    logic [15:0]  tile_shadow [SFF_MAP_WIDTH * SFF_MAP_HEIGHT];
    tile_result_t result_queue [$];

    function automatic logic [8:0] flood_sector(int sx, int sy, logic [15:0] new_code);
        int bx, by, ex, ey, head, tail, cnt, cx, cy, nx, ny, k, nl;
        logic [15:0] old_code;
        bit seen [SFF_SECTOR_SIZE * SFF_SECTOR_SIZE];
        int work [SFF_SECTOR_SIZE * SFF_SECTOR_SIZE];
        old_code = tile_shadow[sy * SFF_MAP_WIDTH + sx];
        if (old_code == new_code)
            return 9'd0;
        bx = (sx / SFF_SECTOR_SIZE) * SFF_SECTOR_SIZE;
        by = (sy / SFF_SECTOR_SIZE) * SFF_SECTOR_SIZE;
        ex = (bx + SFF_SECTOR_SIZE > SFF_MAP_WIDTH) ? SFF_MAP_WIDTH : bx + SFF_SECTOR_SIZE;
        ey = (by + SFF_SECTOR_SIZE > SFF_MAP_HEIGHT) ? SFF_MAP_HEIGHT : by + SFF_SECTOR_SIZE;
        foreach (seen[i])
            seen[i] = 1'b0;
        head = 0;
        tail = 0;
        nl = (sy - by) * SFF_SECTOR_SIZE + (sx - bx);
        seen[nl] = 1'b1;
        tile_shadow[sy * SFF_MAP_WIDTH + sx] = new_code;
        cnt = 1;
        work[tail++] = nl;
        while (head < tail) begin
            cx = bx + work[head] % SFF_SECTOR_SIZE;
            cy = by + work[head] / SFF_SECTOR_SIZE;
            head++;
            for (k = 0; k < 4; k++) begin
                nx = cx + ((k == 2) ? 1 : (k == 3) ? -1 : 0);
                ny = cy + ((k == 0) ? 1 : (k == 1) ? -1 : 0);
                if (nx < bx || ny < by || nx >= ex || ny >= ey)
                    continue;
                nl = (ny - by) * SFF_SECTOR_SIZE + (nx - bx);
                if (seen[nl] || tile_shadow[ny * SFF_MAP_WIDTH + nx] != old_code)
                    continue;
                seen[nl] = 1'b1;
                tile_shadow[ny * SFF_MAP_WIDTH + nx] = new_code;
                cnt++;
                if (tail < SFF_SECTOR_SIZE * SFF_SECTOR_SIZE)
                    work[tail++] = nl;
            end
        end
        return (cnt > 511) ? 9'd511 : cnt[8:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tile_result_t want;
        tile_result_t got;
        int x, y;
        int errs;
        if (!rst_n)
        begin
            error_count   <= 0;
            fill_results  <= 0;
            pending_count <= 0;
        end
        else
        begin
            errs = 0;
            if (m_tvalid && m_tready)
            begin
                got.read_data     = m_tdata[15:0];
                got.changed_count = m_tdata[24:16];
                if (result_queue.size() == 0)
                begin
                    $error("unexpected item: read_data %0d changed_count %0d",
                           got.read_data, got.changed_count);
                    errs++;
                end
                else
                begin
                    want = result_queue[0];
                    result_queue.delete(0);
                    if (got.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0d, actual %0d",
                               want.read_data, got.read_data);
                        errs++;
                    end
                    if (got.changed_count !== want.changed_count)
                    begin
                        $error("changed_count: expected %0d, actual %0d",
                               want.changed_count, got.changed_count);
                        errs++;
                    end
                    if (want.changed_count != 0)
                        fill_results <= fill_results + 1;
                end
            end
            if (s_tvalid && s_tready)
            begin
                x    = 32'(s_tdata[5:0]);
                y    = 32'(s_tdata[11:6]);
                want = '0;
                case (sff_op_t'(s_tuser))
                    SFF_OP_WRITE: tile_shadow[y * SFF_MAP_WIDTH + x] = s_tdata[27:12];
                    SFF_OP_READ:  want.read_data = tile_shadow[y * SFF_MAP_WIDTH + x];
                    SFF_OP_FILL:  want.changed_count = flood_sector(x, y, s_tdata[27:12]);
                    default:      ;
                endcase
                result_queue = {result_queue, want};
            end
            error_count   <= error_count + errs;
            pending_count <= result_queue.size();
        end
    end

endmodule

// ===== tb/sector_flood_fill_unit_test.sv =====
// Top of the sector flood fill unit testbench: clock, reset, stimulus and verdict.
module sector_flood_fill_unit_test;
    import sff_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = SFF_OP_UNUSED;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          error_count, pending_count, fill_results;
    bit          calm = 1'b0;
    bit          tile_written [SFF_MAP_WIDTH * SFF_MAP_HEIGHT];
    int          written_list [$];
    int          sent_items = 0;

    localparam int SEC_X = 48;
    localparam int SEC_Y = 48;

    always #5 clk = ~clk;

    sector_flood_fill_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sector_flood_fill_unit_check u_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .error_count(error_count), .pending_count(pending_count),
        .fill_results(fill_results)
    );

    task automatic send_item(sff_op_t op, int x, int y, logic [15:0] code);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {4'd0, code, y[5:0], x[5:0]};
        s_tvalid = 1'b1;
        #1;
        while (!s_tready)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
        s_tvalid = 1'b0;
        if (op == SFF_OP_WRITE && !tile_written[y * SFF_MAP_WIDTH + x])
        begin
            tile_written[y * SFF_MAP_WIDTH + x] = 1'b1;
            written_list = {written_list, y * SFF_MAP_WIDTH + x};
        end
        sent_items++;
    endtask

    task automatic read_known_tile();
        int a;
        a = written_list[$urandom_range(0, written_list.size() - 1)];
        send_item(SFF_OP_READ, a % SFF_MAP_WIDTH, a / SFF_MAP_WIDTH, 16'($urandom));
    endtask

    function automatic logic [15:0] palette_code();
        case ($urandom_range(0, 5))
            0, 1:    return 16'd5;
            2, 3:    return 16'd9;
            4:       return 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            m_tready = 1'b1;
            #1;
            while (!m_tvalid)
            begin
                @(negedge clk);
                #1;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int order [$];
        int j, pick;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(SFF_OP_WRITE, 0, 0, 16'h0000);
        send_item(SFF_OP_WRITE, 63, 63, 16'hFFFF);
        send_item(SFF_OP_WRITE, 63, 0, 16'hA5A5);
        send_item(SFF_OP_WRITE, 0, 63, 16'h5A5A);
        send_item(SFF_OP_READ, 0, 0, 16'hFFFF);
        send_item(SFF_OP_READ, 63, 63, 16'h0000);
        send_item(SFF_OP_READ, 63, 0, 16'h1234);
        send_item(SFF_OP_READ, 0, 63, 16'h0000);
        send_item(SFF_OP_UNUSED, 63, 63, 16'hFFFF);
        send_item(SFF_OP_UNUSED, 0, 0, 16'h0000);

        // Fill the whole sector with one code, in a shuffled order.
        for (int i = 0; i < SFF_SECTOR_SIZE * SFF_SECTOR_SIZE; i++)
            order = {order, i};
        order.shuffle();
        foreach (order[i])
            send_item(SFF_OP_WRITE, SEC_X + order[i] % SFF_SECTOR_SIZE,
                      SEC_Y + order[i] / SFF_SECTOR_SIZE, 16'd5);

        send_item(SFF_OP_FILL, 50, 50, 16'd9);
        send_item(SFF_OP_FILL, 63, 63, 16'd9);
        send_item(SFF_OP_WRITE, 48, 49, 16'd3);
        send_item(SFF_OP_WRITE, 49, 48, 16'd3);
        send_item(SFF_OP_FILL, 48, 48, 16'hFFFF);
        send_item(SFF_OP_FILL, 63, 48, 16'h0000);
        send_item(SFF_OP_READ, 48, 48, 16'd0);

        for (j = 0; j < 300; j++)
        begin
            if (j % 60 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (j == 150)
                while (pending_count != 0)
                    @(negedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_item(SFF_OP_WRITE, SEC_X + $urandom_range(0, 15),
                          SEC_Y + $urandom_range(0, 15), palette_code());
            else if (pick < 58)
                send_item(SFF_OP_FILL, SEC_X + $urandom_range(0, 15),
                          SEC_Y + $urandom_range(0, 15), palette_code());
            else if (pick < 83)
                read_known_tile();
            else if (pick < 95)
                send_item(SFF_OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                          16'($urandom));
            else
                send_item(SFF_OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                          16'($urandom));
        end
        s_tvalid = 1'b0;
        calm = 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d items: writes, reads, unused opcodes and sector fills.", sent_items);
        $display("%0d fills changed tiles; %0d mismatches.", fill_results, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
